// File: hdl/zsema_pkg.sv
// shared constants, register codes and sequencer states of the z-score gated ema filter
package zsema_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 256;

  localparam logic [15:0] WEIGHT_RESET = 16'd45875;
  localparam logic [8:0]  LENGTH_RESET = 9'd200;
  localparam int unsigned CFG_DATA_W   = 16;

  // configuration register indexes
  localparam logic CFG_WEIGHT = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  localparam int unsigned Z_LIMIT     = 3;
  localparam logic [15:0] SCORE_LIMIT = 16'(Z_LIMIT * 256);
  localparam logic [15:0] SCORE_MAX   = 16'hFFFF;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_MEAN,
    S_SQ,
    S_VAR,
    S_SQRT,
    S_SCORE,
    S_EMA,
    S_EMIT
  } state_e;

endpackage

// File: hdl/zsema_ram.sv
// generic simple dual port ram with registered read
module zsema_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/zsema_div.sv
// bit-serial restoring unsigned divider, one quotient bit per cycle
module zsema_div #(
  parameter int unsigned NUM_W = 72,
  parameter int unsigned DEN_W = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [NUM_W-1:0]           num_i,   // msb aligned
  input  logic [DEN_W-1:0]           den_i,
  input  logic [$clog2(NUM_W+1)-1:0] iters_i,
  output logic                       done_o,
  output logic [NUM_W-1:0]           quot_o,
  output logic [DEN_W-1:0]           rem_o
);

  localparam int unsigned ITW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, quot_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_q, rem_t, rem_n;
  logic [ITW-1:0]   cnt_q;
  logic             busy_q, done_q, ge;

  always_comb begin
    rem_t = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
    ge    = rem_t >= {1'b0, den_q};
    rem_n = ge ? rem_t - {1'b0, den_q} : rem_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      quot_q <= '0;
      den_q  <= '0;
      rem_q  <= '0;
    end else if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
      cnt_q  <= iters_i;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      num_q  <= {num_q[NUM_W-2:0], 1'b0};
      rem_q  <= rem_n;
      quot_q <= {quot_q[NUM_W-2:0], ge};
      cnt_q  <= cnt_q - ITW'(1);
      if (cnt_q == ITW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[DEN_W-1:0];

endmodule

// File: hdl/zscore_gated_ema_filter.sv
// top level of the z-score gated ema filter for 3-d points
//
// usage: one input beat (raw_x/y/z, signed q16.16) gives exactly one output beat
// (smooth point, three q8.8 scores, outlier and window-ready flags). both
// channels use valid/stall; a beat moves when valid is high and stall is low.
// the window lives in one ram of 96-bit entries, read one entry per cycle.
// while the window fills, an accepted item goes straight to the emit state and
// its result is registered into the output register. with a full window,
// an item's time is set by the two passes over the window ram (sum, then
// squared deviations) and by the shared bit-serial divider and the
// 2-bit-per-cycle square root. an axis with zero deviation skips its score division.
// one item is worked at a time; the input stalls from accept until the
// result has moved into the output register, which holds it while the
// receiver stalls. the next item may be accepted while it waits there.
// reset empties the window (fill count zero), clears the last point and
// scores and loads the register defaults; the ram itself is not cleared,
// since entries beyond the fill count are never read.
// configuration writes are taken at any cycle and are meant for idle time.
module zscore_gated_ema_filter #(
  parameter int unsigned WINDOW_DEPTH = zsema_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [zsema_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [31:0]                   raw_x_i,
  input  logic signed [31:0]                   raw_y_i,
  input  logic signed [31:0]                   raw_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [31:0]                   smooth_x_o,
  output logic signed [31:0]                   smooth_y_o,
  output logic signed [31:0]                   smooth_z_o,
  output logic [15:0]                          score_x_o,
  output logic [15:0]                          score_y_o,
  output logic [15:0]                          score_z_o,
  output logic                                 outlier_flag_o,
  output logic                                 window_ready_o
);
  import zsema_pkg::*;

  localparam int unsigned IW    = $clog2(WINDOW_DEPTH);
  localparam int unsigned CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W = 32 + CW;
  localparam int unsigned SQ_W  = 64 + CW;
  localparam int unsigned NUM_W = SQ_W;
  localparam int unsigned ITW   = $clog2(NUM_W + 1);
  localparam int unsigned SCN_W = 40;

  // ring index add, both operands below the depth
  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IW+1)'(WINDOW_DEPTH)) begin
      s = s - (IW+1)'(WINDOW_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  // configuration
  logic [15:0] weight_q;
  logic [8:0]  len_q;
  logic [CW-1:0] eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RESET;
      len_q    <= LENGTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WEIGHT: weight_q <= cfg_data_i[15:0];
        CFG_LENGTH: len_q    <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // window length clamped to 2 .. depth
  always_comb begin
    if (len_q < 9'd2) begin
      eff = CW'(2);
    end else if (32'(len_q) > WINDOW_DEPTH) begin
      eff = CW'(WINDOW_DEPTH);
    end else begin
      eff = CW'(len_q);
    end
  end

  // control state
  state_e        state_q, state_d;
  logic [CW-1:0] fill_q, n_q, cnt_q;
  logic [IW-1:0] oldest_q;
  logic [1:0]    ax_q, ax_next;
  logic          go_q, phase_q, full_q, rv1_q, rv2_q, rv3_q;
  logic [5:0]    sq_cnt_q;
  logic          out_valid_q;

  // datapath registers
  logic signed [31:0]      p_q [3];
  logic signed [SUM_W-1:0] sum_q [3];
  logic signed [31:0]      mean_q [3];
  logic [31:0]             absd_q [3];
  logic [63:0]             sq_q [3];
  logic [SQ_W-1:0]         acc_q [3];
  logic [15:0]             sc_q [3];
  logic signed [31:0]      ema_q [3];
  logic signed [31:0]      prev_smooth_q [3];
  logic [15:0]             prev_score_q [3];
  logic [95:0]             last_q;
  logic [63:0]             var_q;
  logic [34:0]             srem_q;
  logic [31:0]             root_q;
  logic signed [48:0]      m1_q;
  logic signed [49:0]      m2_q;
  logic signed [31:0]      out_smooth_q [3];
  logic [15:0]             out_score_q [3];
  logic                    out_flag_q, out_ready_q;

  // ram
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [95:0]   ram_wdata, ram_rdata;
  logic signed [31:0] rd [3];

  zsema_ram #(
    .WIDTH(96),
    .DEPTH(WINDOW_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd[0] = $signed(ram_rdata[31:0]);
  assign rd[1] = $signed(ram_rdata[63:32]);
  assign rd[2] = $signed(ram_rdata[95:64]);

  // shared divider
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quot;
  logic [31:0]      div_den, div_rem;
  logic [ITW-1:0]   div_iters;

  zsema_div #(
    .NUM_W(NUM_W),
    .DEN_W(32)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .iters_i(div_iters),
    .done_o (div_done),
    .quot_o (div_quot),
    .rem_o  (div_rem)
  );

  // common decode
  logic in_fire, fill_case, issue, emit_fire, score_adv, outlier;
  logic sum_neg;
  logic [SUM_W-1:0] sum_mag, mean_mag, mean_s;
  logic signed [32:0] dn;
  logic [31:0] absdn;
  logic [34:0] srem_t, strial;
  logic signed [16:0] w_s;
  logic signed [17:0] wc_s;
  logic signed [50:0] ema_acc;
  logic signed [31:0] res [3];

  assign in_fire   = in_valid_i && (state_q == S_IDLE);
  assign fill_case = fill_q < eff;
  assign issue     = ((state_q == S_SUM) || (state_q == S_SQ)) && (cnt_q < n_q);
  assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);
  assign score_adv = (state_q == S_SCORE) && ((!go_q && root_q == '0) || (go_q && div_done));
  assign outlier   = (sc_q[0] > SCORE_LIMIT) || (sc_q[1] > SCORE_LIMIT);
  assign ax_next   = (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;

  always_comb begin
    sum_neg  = sum_q[ax_q][SUM_W-1];
    sum_mag  = sum_neg ? SUM_W'(-sum_q[ax_q]) : SUM_W'(sum_q[ax_q]);
    // floor division: round magnitude up for a negative sum
    mean_mag = div_quot[SUM_W-1:0] + SUM_W'(sum_neg && (div_rem != '0));
    mean_s   = sum_neg ? -mean_mag : mean_mag;
    dn       = 33'(p_q[ax_q]) - 33'(mean_q[ax_q]);
    absdn    = dn[32] ? 32'(-dn) : dn[31:0];
    srem_t   = {srem_q[32:0], var_q[63:62]};
    strial   = {1'b0, root_q, 2'b01};
    w_s      = $signed({1'b0, weight_q});
    wc_s     = $signed({1'b0, 17'h10000 - {1'b0, weight_q}});
    ema_acc  = 51'(m1_q) + 51'(m2_q) + 51'(32768);
    for (int k = 0; k < 3; k++) begin
      res[k] = outlier ? p_q[k] : ema_q[k];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = fill_case ? S_EMIT : S_SUM;
      S_SUM:   if (!issue && !rv1_q) state_d = S_MEAN;
      S_MEAN:  if (go_q && div_done && ax_q == 2'd2) state_d = S_SQ;
      S_SQ:    if (!issue && !rv1_q && !rv2_q && !rv3_q) state_d = S_VAR;
      S_VAR:   if (go_q && div_done) state_d = S_SQRT;
      S_SQRT:  if (go_q && sq_cnt_q == 6'd1) state_d = S_SCORE;
      S_SCORE: if (score_adv) state_d = (ax_q == 2'd2) ? S_EMA : S_VAR;
      S_EMA:   if (phase_q && ax_q == 2'd2) state_d = S_EMIT;
      S_EMIT:  if (emit_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs: divider requests and ram ports
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = 32'(n_q);
    div_iters = ITW'(SQ_W);
    case (state_q)
      S_MEAN: begin
        div_start = !go_q;
        div_num   = NUM_W'(sum_mag) << (NUM_W - SUM_W);
        div_iters = ITW'(SUM_W);
      end
      S_VAR: begin
        div_start = !go_q;
        div_num   = NUM_W'(acc_q[ax_q]);
      end
      S_SCORE: begin
        div_start = !go_q && (root_q != '0);
        div_num   = NUM_W'({absdn, 8'h00}) << (NUM_W - SCN_W);
        div_den   = root_q;
        div_iters = ITW'(SCN_W);
      end
      default: ;
    endcase

    ram_raddr = ring_add(oldest_q, cnt_q[IW-1:0]);
    if (state_q == S_IDLE) begin
      ram_we    = in_fire && fill_case && (raw_x_i != '0);
      ram_waddr = ring_add(oldest_q, fill_q[IW-1:0]);
      ram_wdata = {raw_z_i, raw_y_i, raw_x_i};
    end else begin
      ram_we    = emit_fire && full_q;
      ram_waddr = ring_add(oldest_q, n_q[IW-1:0]);
      ram_wdata = outlier ? last_q : {ema_q[2], ema_q[1], ema_q[0]};
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      oldest_q    <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      ax_q        <= '0;
      go_q        <= 1'b0;
      phase_q     <= 1'b0;
      full_q      <= 1'b0;
      rv1_q       <= 1'b0;
      rv2_q       <= 1'b0;
      rv3_q       <= 1'b0;
      sq_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        prev_smooth_q[k] <= '0;
        prev_score_q[k]  <= '0;
      end
    end else begin
      state_q <= state_d;
      rv1_q   <= issue;
      rv2_q   <= rv1_q && (state_q == S_SQ);
      rv3_q   <= rv2_q;
      if (issue) begin
        cnt_q <= cnt_q + CW'(1);
      end

      if (in_fire) begin
        if (fill_case) begin
          full_q <= 1'b0;
          if (raw_x_i != '0) begin
            fill_q <= fill_q + CW'(1);
          end
        end else begin
          // drop the oldest point, score against the rest
          full_q   <= 1'b1;
          oldest_q <= ring_add(oldest_q, IW'(1));
          n_q      <= fill_q - CW'(1);
          cnt_q    <= '0;
          ax_q     <= '0;
        end
      end

      if (div_start) begin
        go_q <= 1'b1;
      end else if (go_q && div_done) begin
        go_q <= 1'b0;
      end

      if (state_q == S_MEAN && go_q && div_done) begin
        ax_q <= ax_next;
        if (ax_q == 2'd2) begin
          cnt_q <= '0;
        end
      end

      if (state_q == S_SQRT) begin
        if (!go_q) begin
          go_q     <= 1'b1;
          sq_cnt_q <= 6'd32;
        end else begin
          sq_cnt_q <= sq_cnt_q - 6'd1;
          if (sq_cnt_q == 6'd1) begin
            go_q <= 1'b0;
          end
        end
      end

      if (score_adv) begin
        ax_q <= ax_next;
      end

      if (state_q == S_EMA) begin
        phase_q <= !phase_q;
        if (phase_q) begin
          ax_q <= ax_next;
        end
      end

      if (emit_fire) begin
        out_valid_q <= 1'b1;
        if (full_q) begin
          for (int k = 0; k < 3; k++) begin
            prev_smooth_q[k] <= res[k];
            prev_score_q[k]  <= sc_q[k];
          end
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      p_q[0] <= raw_x_i;
      p_q[1] <= raw_y_i;
      p_q[2] <= raw_z_i;
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= '0;
        acc_q[k] <= '0;
      end
    end

    // first pass: per-axis sums
    if (state_q == S_SUM && rv1_q) begin
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= sum_q[k] + SUM_W'(rd[k]);
      end
    end

    if (state_q == S_MEAN && go_q && div_done) begin
      mean_q[ax_q] <= mean_s[31:0];
    end

    // second pass: |d|, d*d, accumulate
    if (state_q == S_SQ) begin
      if (rv1_q) begin
        last_q <= ram_rdata;
        for (int k = 0; k < 3; k++) begin
          logic signed [32:0] dd;
          dd = 33'(rd[k]) - 33'(mean_q[k]);
          absd_q[k] <= dd[32] ? 32'(-dd) : dd[31:0];
        end
      end
      if (rv2_q) begin
        for (int k = 0; k < 3; k++) begin
          sq_q[k] <= absd_q[k] * absd_q[k];
        end
      end
      if (rv3_q) begin
        for (int k = 0; k < 3; k++) begin
          acc_q[k] <= acc_q[k] + SQ_W'(sq_q[k]);
        end
      end
    end

    if (state_q == S_VAR && go_q && div_done) begin
      var_q <= div_quot[63:0];
    end

    // integer square root, two radicand bits per cycle
    if (state_q == S_SQRT) begin
      if (!go_q) begin
        srem_q <= '0;
        root_q <= '0;
      end else begin
        var_q <= {var_q[61:0], 2'b00};
        if (srem_t >= strial) begin
          srem_q <= srem_t - strial;
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          srem_q <= srem_t;
          root_q <= {root_q[30:0], 1'b0};
        end
      end
    end

    if (state_q == S_SCORE) begin
      if (!go_q && root_q == '0) begin
        // zero deviation
        sc_q[ax_q] <= (absdn != '0) ? SCORE_MAX : '0;
      end else if (go_q && div_done) begin
        sc_q[ax_q] <= (|div_quot[NUM_W-1:16]) ? SCORE_MAX : div_quot[15:0];
      end
    end

    if (state_q == S_EMA) begin
      if (!phase_q) begin
        m1_q <= w_s * p_q[ax_q];
        m2_q <= wc_s * prev_smooth_q[ax_q];
      end else begin
        ema_q[ax_q] <= ema_acc[47:16];
      end
    end

    if (emit_fire) begin
      for (int k = 0; k < 3; k++) begin
        out_smooth_q[k] <= full_q ? res[k] : prev_smooth_q[k];
        out_score_q[k]  <= full_q ? sc_q[k] : prev_score_q[k];
      end
      out_flag_q  <= full_q && outlier;
      out_ready_q <= full_q;
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign smooth_x_o     = out_smooth_q[0];
  assign smooth_y_o     = out_smooth_q[1];
  assign smooth_z_o     = out_smooth_q[2];
  assign score_x_o      = out_score_q[0];
  assign score_y_o      = out_score_q[1];
  assign score_z_o      = out_score_q[2];
  assign outlier_flag_o = out_flag_q;
  assign window_ready_o = out_ready_q;

endmodule

// File: tb/tb.sv
// self-checking testbench for the z-score gated ema filter
module tb;
  import zsema_pkg::*;

  localparam int unsigned DEPTH      = 256;
  localparam int unsigned CYCLE_CAP  = 4000000;
  localparam int unsigned LONG_HOLD  = 3000;
  localparam int unsigned FIFO_DEPTH = 1024;
  localparam int unsigned ROW_MAX    = 64;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic [15:0]        cz;
    logic               outlier;
    logic               ready;
  } beat_t;

  typedef struct {
    bit    typed;
    beat_t val;
  } typed_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic               idx;
    logic [15:0]        data;
    logic signed [31:0] x, y, z;
    bit                 typed;
    beat_t              val;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_idx = CFG_WEIGHT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] raw_x = '0, raw_y = '0, raw_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] smooth_x, smooth_y, smooth_z;
  logic [15:0] score_x, score_y, score_z;
  logic outlier_flag, window_ready;

  zscore_gated_ema_filter dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .raw_x_i(raw_x), .raw_y_i(raw_y), .raw_z_i(raw_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .smooth_x_o(smooth_x), .smooth_y_o(smooth_y), .smooth_z_o(smooth_z),
    .score_x_o(score_x), .score_y_o(score_y), .score_z_o(score_z),
    .outlier_flag_o(outlier_flag), .window_ready_o(window_ready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // filter model state, mirrors the block
  logic [15:0]        mdl_weight;
  logic [8:0]         mdl_length;
  logic signed [31:0] ring [3][DEPTH];
  int unsigned        ring_fill;
  int unsigned        ring_head;
  logic signed [31:0] last_point [3];
  logic [15:0]        last_score [3];

  // expected results and typed-in overrides, as ring buffers
  beat_t       expected_beats [FIFO_DEPTH];
  int unsigned exp_wr, exp_rd;
  typed_t      typed_beats [FIFO_DEPTH];
  int unsigned typed_wr, typed_rd;
  int unsigned fails, beats_seen, outliers_seen, ready_seen, cycles;
  bit quiet;
  int unsigned hold_tickets, holds_seen;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint floor_div(longint a, longint n);
    if (a >= 0) return a / n;
    return -(((-a) + n - 1) / n);
  endfunction

  // abs z-score of p on one axis over n ring points starting at the head
  function automatic logic [15:0] axis_zscore(int axis, int unsigned n, logic signed [31:0] p);
    longint sum, mean, d;
    logic [127:0] sq_acc;
    logic [63:0] mag, var_q, sd, q;
    sum = 0;
    sq_acc = '0;
    for (int unsigned i = 0; i < n; i++) sum += ring[axis][(ring_head + i) % DEPTH];
    mean = floor_div(sum, longint'(n));
    for (int unsigned i = 0; i < n; i++) begin
      d = longint'(ring[axis][(ring_head + i) % DEPTH]) - mean;
      mag = (d < 0) ? -d : d;
      sq_acc += {64'd0, mag} * {64'd0, mag};
    end
    var_q = 64'(sq_acc / 128'(n));
    sd = int_sqrt(var_q);
    d = longint'(p) - mean;
    mag = (d < 0) ? -d : d;
    if (sd == 0) return (mag != 0) ? SCORE_MAX : 16'd0;
    q = (mag << 8) / sd;
    return (q > 64'(SCORE_MAX)) ? SCORE_MAX : q[15:0];
  endfunction

  function automatic beat_t filter_step(logic signed [31:0] px, logic signed [31:0] py,
                                        logic signed [31:0] pz);
    beat_t r;
    logic signed [31:0] p [3];
    logic signed [31:0] o [3];
    logic [15:0] sc [3];
    int unsigned eff, n, slot, prior;
    longint acc;
    p[0] = px; p[1] = py; p[2] = pz;
    eff = mdl_length;
    if (eff < 2) eff = 2;
    if (eff > DEPTH) eff = DEPTH;
    r.outlier = 1'b0;
    r.ready = 1'b0;
    if (ring_fill < eff) begin
      // filling: zero x is dropped, output repeats the last result
      if (px != 0) begin
        slot = (ring_head + ring_fill) % DEPTH;
        for (int k = 0; k < 3; k++) ring[k][slot] = p[k];
        ring_fill++;
      end
      for (int k = 0; k < 3; k++) begin
        o[k] = last_point[k];
        sc[k] = last_score[k];
      end
    end else begin
      r.ready = 1'b1;
      ring_head = (ring_head + 1) % DEPTH;
      n = ring_fill - 1;
      for (int k = 0; k < 3; k++) sc[k] = axis_zscore(k, n, p[k]);
      r.outlier = (sc[0] > SCORE_LIMIT) || (sc[1] > SCORE_LIMIT);
      slot = (ring_head + n) % DEPTH;
      prior = (ring_head + n - 1) % DEPTH;
      for (int k = 0; k < 3; k++) begin
        if (r.outlier) begin
          o[k] = p[k];
          ring[k][slot] = ring[k][prior];
        end else begin
          acc = longint'(mdl_weight) * longint'(p[k])
              + (longint'(65536) - longint'(mdl_weight)) * longint'(last_point[k]) + 32768;
          o[k] = 32'(acc >>> 16);
          ring[k][slot] = o[k];
        end
        last_point[k] = o[k];
        last_score[k] = sc[k];
      end
      ring_fill = n + 1;
    end
    r.sx = o[0]; r.sy = o[1]; r.sz = o[2];
    r.cx = sc[0]; r.cy = sc[1]; r.cz = sc[2];
    return r;
  endfunction

  // input side: every accepted beat steps the model
  always @(posedge clk_i) begin
    typed_t t;
    beat_t  e;
    if (rst_ni && in_valid && !in_stall) begin
      e = filter_step(raw_x, raw_y, raw_z);
      t = typed_beats[typed_rd % FIFO_DEPTH];
      typed_rd++;
      expected_beats[exp_wr % FIFO_DEPTH] = t.typed ? t.val : e;
      exp_wr++;
    end
  end

  // output side: random stall per beat, plus one long hold on request
  int unsigned stall_left, long_left;
  always @(posedge clk_i) begin
    beat_t got, want;
    int unsigned d;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        got = '{smooth_x, smooth_y, smooth_z, score_x, score_y, score_z,
                outlier_flag, window_ready};
        beats_seen++;
        if (got.outlier) outliers_seen++;
        if (got.ready) ready_seen++;
        if (exp_wr == exp_rd) begin
          $error("unexpected output beat");
          fails++;
        end else begin
          want = expected_beats[exp_rd % FIFO_DEPTH];
          exp_rd++;
          if (got.sx !== want.sx) begin
            $error("smooth_x exp %0d got %0d", want.sx, got.sx); fails++;
          end
          if (got.sy !== want.sy) begin
            $error("smooth_y exp %0d got %0d", want.sy, got.sy); fails++;
          end
          if (got.sz !== want.sz) begin
            $error("smooth_z exp %0d got %0d", want.sz, got.sz); fails++;
          end
          if (got.cx !== want.cx) begin
            $error("score_x exp %0d got %0d", want.cx, got.cx); fails++;
          end
          if (got.cy !== want.cy) begin
            $error("score_y exp %0d got %0d", want.cy, got.cy); fails++;
          end
          if (got.cz !== want.cz) begin
            $error("score_z exp %0d got %0d", want.cz, got.cz); fails++;
          end
          if (got.outlier !== want.outlier) begin
            $error("outlier_flag exp %0d got %0d", want.outlier, got.outlier); fails++;
          end
          if (got.ready !== want.ready) begin
            $error("window_ready exp %0d got %0d", want.ready, got.ready); fails++;
          end
        end
      end
      if (holds_seen != hold_tickets) begin
        holds_seen++;
        long_left = LONG_HOLD;
      end
      if (long_left > 0) begin
        long_left--;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        d = quiet ? 0 : $urandom_range(0, 11);
        stall_left = d;
        out_stall <= (d > 0);
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= (stall_left > 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, bit typed, beat_t val);
    int unsigned gap;
    typed_t t;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    t.typed = typed;
    t.val = val;
    typed_beats[typed_wr % FIFO_DEPTH] = t;
    typed_wr++;
    raw_x <= x; raw_y <= y; raw_z <= z;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
  endtask

  // sender pause: drop valid and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (exp_wr != exp_rd || typed_wr != typed_rd) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    drain();
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= data;
    if (idx == CFG_WEIGHT) mdl_weight = data;
    else mdl_length = data[8:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  row_t rows [ROW_MAX];
  int unsigned row_count;
  task automatic add_item(logic signed [31:0] x, y, z, bit typed = 0, beat_t val = '0);
    row_t r;
    r.kind = ROW_ITEM; r.idx = CFG_WEIGHT; r.data = '0;
    r.x = x; r.y = y; r.z = z; r.typed = typed; r.val = val;
    rows[row_count] = r;
    row_count++;
  endtask
  task automatic add_cfg(logic idx, logic [15:0] data);
    row_t r;
    r.kind = ROW_CFG; r.idx = idx; r.data = data;
    r.x = 0; r.y = 0; r.z = 0; r.typed = 0; r.val = '0;
    rows[row_count] = r;
    row_count++;
  endtask

  // random point: mostly a noisy cluster, sometimes jumps, zero x and raw noise
  logic signed [31:0] base [3];
  function automatic logic signed [31:0] pick_coord(int k, int mode, int unsigned amp);
    logic signed [31:0] v;
    case (mode)
      0: v = base[k] + $signed($urandom_range(0, 2 * amp)) - $signed(amp);
      1: v = base[k] + (($urandom_range(0, 1) != 0) ? 32'sh0100_0000 : -32'sh0100_0000);
      2: v = $urandom();
      default: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = -32'sd1;
          default: v = 32'sd0;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic random_phase(int unsigned count, int unsigned hold_at, int unsigned pause_at);
    int unsigned roll, amp;
    int mode;
    logic signed [31:0] p [3];
    for (int k = 0; k < 3; k++) base[k] = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh10_0000;
    if (base[0] == 0) base[0] = 32'sd1;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == hold_at) hold_tickets++;
      if (i == pause_at) drain();
      roll = $urandom_range(0, 99);
      mode = (roll < 72) ? 0 : (roll < 82) ? 1 : (roll < 92) ? 2 : 3;
      case ($urandom_range(0, 2))
        0: amp = 0;
        1: amp = 16;
        default: amp = 4096;
      endcase
      for (int k = 0; k < 3; k++) p[k] = pick_coord(k, mode, amp);
      if ($urandom_range(0, 19) == 0) p[0] = 0;
      send_point(p[0], p[1], p[2], 0, '0);
    end
  endtask

  initial begin
    beat_t zero_beat;
    zero_beat = '0;
    mdl_weight = WEIGHT_RESET;
    mdl_length = LENGTH_RESET;
    ring_fill = 0;
    ring_head = 0;
    for (int k = 0; k < 3; k++) begin
      last_point[k] = 0;
      last_score[k] = 0;
    end

    // filling at reset length: outputs repeat the cleared last result
    add_item(32'sd0, 32'sd5, 32'sd9, 1, zero_beat);
    add_item(32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 1, zero_beat);
    add_item(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1, 1, zero_beat);
    // shrink to two: window full, single-point stats give zero deviation
    add_cfg(CFG_LENGTH, 16'd2);
    add_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    add_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    add_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    add_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    add_cfg(CFG_LENGTH, 16'd3);
    add_item(32'sh0001_0100, 32'sh0002_0000, 32'sh0003_0000);
    add_item(32'sh0001_0000, 32'sh0002_0100, 32'sh0003_0000);
    add_item(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    add_cfg(CFG_WEIGHT, 16'd0);
    add_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    add_item(32'sh0001_0040, 32'sh0002_0040, 32'sh0003_0040);
    add_cfg(CFG_WEIGHT, 16'hFFFF);
    add_item(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    add_item(-32'sd1, -32'sd1, -32'sd1);
    // out of range lengths clamp to the limits
    add_cfg(CFG_LENGTH, 16'd0);
    add_item(32'sh0000_8000, 32'sh0000_8000, 32'sh8000_0000);
    add_item(32'sh0000_8000, 32'sh0000_8000, 32'sh8000_0000);
    add_cfg(CFG_LENGTH, 16'hFFFF);
    add_item(32'sd0, 32'sd0, 32'sd0);
    add_item(32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < row_count; i++) begin
      if (rows[i].kind == ROW_CFG) write_reg(rows[i].idx, rows[i].data);
      else send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].val);
    end

    write_reg(CFG_LENGTH, 16'd2);
    write_reg(CFG_WEIGHT, 16'hFFFF);
    random_phase(60, ~0, ~0);
    write_reg(CFG_WEIGHT, 16'd0);
    write_reg(CFG_LENGTH, 16'd4);
    random_phase(60, 10, 35);
    write_reg(CFG_LENGTH, 16'd3);
    write_reg(CFG_WEIGHT, 16'($urandom_range(0, 65535)));
    random_phase(50, ~0, ~0);
    write_reg(CFG_LENGTH, 16'($urandom_range(5, 16)));
    write_reg(CFG_WEIGHT, 16'($urandom_range(0, 65535)));
    quiet = 1;
    random_phase(80, ~0, ~0);
    quiet = 0;
    // widest window, then lowered length keeps the full size
    write_reg(CFG_LENGTH, 16'd256);
    write_reg(CFG_WEIGHT, WEIGHT_RESET);
    random_phase(270, ~0, ~0);
    write_reg(CFG_LENGTH, 16'd8);
    write_reg(CFG_WEIGHT, 16'($urandom_range(0, 65535)));
    random_phase(40, ~0, ~0);

    in_valid <= 1'b0;
    while (exp_wr != exp_rd || typed_wr != typed_rd) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d beats: %0d with full window, %0d rejected as outliers",
             beats_seen, ready_seen, outliers_seen);
    $display("window lengths 0..511 incl. clamps, weights 0 and full scale");
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/zsema_pkg.sv
hdl/zsema_ram.sv
hdl/zsema_div.sv
hdl/zscore_gated_ema_filter.sv
tb/tb.sv
